@@ rtl/bba_pkg.sv @@
// Shared types and constants for the bitmap block allocator.
// No dependencies; every rtl file imports this package.
package bba_pkg;

    localparam int ID_W  = 12;          // block id and granted block width
    localparam int BN_W  = 13;          // internal block number / count width
    localparam int ST_W  = 2;           // result status width
    localparam int IDX_W = 2;           // config register index width
    localparam int BN_MAX = (2 ** BN_W) - 1;

    localparam logic [IDX_W-1:0] REG_FIRST_DATA_BLOCK = 2'd0;
    localparam logic [IDX_W-1:0] REG_BLOCK_COUNT      = 2'd1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0] first_data_block;
        logic [BN_W-1:0] limit;            // block count saturated to capacity
    } t_cfg;

endpackage

@@ rtl/bitmap_block_allocator_top.sv @@
// Top level of the bitmap first-fit block allocator: config registers,
// sequencer (bba_ctrl) and usage map memory (bba_map_ram). Depends on bba_pkg.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+--------------------------
//  request   | i_kind, i_block_id                      | i_start && !o_busy
//  result    | o_granted_block, o_status               | o_valid, one-cycle strobe
//  config    | i_cfg_idx, i_cfg_data                   | i_cfg_we, no wait
//
// After reset the map is cleared one word per cycle: o_busy stays high until all
// ceil(NUM_BLOCKS / MAP_WORD_BITS) map words (128 at the defaults) are zeroed.
// Allocate: the first read is issued on acceptance, then one map word per cycle
// is examined from the first data block's word up to the last word in range.
// Free: read, then write back. Out-of-range frees and allocates with no search
// range are answered from idle. The result appears the cycle after the last step.
// The receiver cannot stall; every result is a single-cycle beat.
module bitmap_block_allocator_top
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS    = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic             i_kind,
    input  logic [ID_W-1:0]  i_block_id,
    output logic             o_valid,
    output logic [ID_W-1:0]  o_granted_block,
    output logic [ST_W-1:0]  o_status,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [BN_W-1:0]  i_cfg_data
);

    localparam int DEPTH = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP   = (NUM_BLOCKS < BN_MAX) ? NUM_BLOCKS : BN_MAX;

    logic [ID_W-1:0]          r_first_data_block;
    logic [BN_W-1:0]          r_block_count;
    t_cfg                     cfg;
    logic                     re;
    logic                     we;
    logic [AW-1:0]            raddr;
    logic [AW-1:0]            waddr;
    logic [MAP_WORD_BITS-1:0] rdata;
    logic [MAP_WORD_BITS-1:0] wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_data_block <= '0;
            r_block_count      <= BN_W'(4096);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FIRST_DATA_BLOCK) begin
                r_first_data_block <= i_cfg_data[ID_W-1:0];
            end else if (i_cfg_idx == REG_BLOCK_COUNT) begin
                r_block_count <= i_cfg_data;
            end
        end
    end

    always_comb begin
        cfg.first_data_block = r_first_data_block;
        cfg.limit = (r_block_count > BN_W'(CAP)) ? BN_W'(CAP) : r_block_count;
    end

    bba_ctrl #(
        .DEPTH (DEPTH),
        .WB    (MAP_WORD_BITS),
        .AW    (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_kind          (i_kind),
        .i_block_id      (i_block_id),
        .i_cfg           (cfg),
        .o_busy          (o_busy),
        .o_valid         (o_valid),
        .o_granted_block (o_granted_block),
        .o_status        (o_status),
        .o_re            (re),
        .o_raddr         (raddr),
        .i_rdata         (rdata),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata)
    );

    bba_map_ram #(
        .DEPTH (DEPTH),
        .WB    (MAP_WORD_BITS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata)
    );

endmodule

@@ rtl/bba_map_ram.sv @@
// Usage map storage: one word of map bits per entry, one write and one read port.
// Read data is registered. Uses bba_pkg only by convention.
module bba_map_ram
    import bba_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int WB    = 32,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [WB-1:0] o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [WB-1:0] i_wdata
);

    logic [WB-1:0] r_mem [DEPTH];
    logic [WB-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bba_ctrl.sv @@
// Request sequencer: map clearing pass, word-by-word first-fit scan, free
// read-modify-write, and the result register. Depends on bba_pkg.
module bba_ctrl
    import bba_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int WB    = 32,
    parameter int AW    = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_kind,
    input  logic [ID_W-1:0] i_block_id,
    input  t_cfg            i_cfg,
    output logic            o_busy,
    output logic            o_valid,
    output logic [ID_W-1:0] o_granted_block,
    output logic [ST_W-1:0] o_status,
    output logic            o_re,
    output logic [AW-1:0]   o_raddr,
    input  logic [WB-1:0]   i_rdata,
    output logic            o_we,
    output logic [AW-1:0]   o_waddr,
    output logic [WB-1:0]   o_wdata
);

    localparam int SH = $clog2(WB);
    localparam logic [WB-1:0] ONES = {WB{1'b1}};
    localparam logic [SH-1:0] TOP_BIT = SH'(WB - 1);

    t_state          r_state, n_state;
    logic [BN_W-1:0] r_word, n_word;
    logic [SH-1:0]   r_bit, n_bit;
    logic [AW-1:0]   r_clr, n_clr;
    logic            r_valid, n_valid;
    logic [ID_W-1:0] r_granted, n_granted;
    t_status         r_status, n_status;

    logic            accept;
    logic [BN_W-1:0] fdb_ext;
    logic [BN_W-1:0] fdb_word;
    logic [BN_W-1:0] lim_m1;
    logic [BN_W-1:0] last_word;
    logic [BN_W-1:0] id_word;
    logic [WB-1:0]   lo_mask;
    logic [WB-1:0]   hi_mask;
    logic [WB-1:0]   avail;
    logic            found;
    logic [SH-1:0]   found_idx;
    logic [BN_W-1:0] grant_bn;

    function automatic logic [SH-1:0] lowest_set(input logic [WB-1:0] v);
        logic [SH-1:0] idx;
        idx = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SH'(i);
            end
        end
        return idx;
    endfunction

    assign accept    = i_start && (r_state == S_IDLE);
    assign fdb_ext   = BN_W'(i_cfg.first_data_block);
    assign fdb_word  = fdb_ext >> SH;
    assign lim_m1    = i_cfg.limit - BN_W'(1);
    assign last_word = lim_m1 >> SH;
    assign id_word   = BN_W'(i_block_id) >> SH;

    // only blocks in [first_data_block, limit) are candidates
    always_comb begin
        lo_mask   = (r_word == fdb_word) ? (ONES << fdb_ext[SH-1:0]) : ONES;
        hi_mask   = (r_word == last_word) ? (ONES >> (TOP_BIT - lim_m1[SH-1:0])) : ONES;
        avail     = ~i_rdata & lo_mask & hi_mask;
        found     = |avail;
        found_idx = lowest_set(avail);
        grant_bn  = (r_word << SH) | BN_W'(found_idx);
    end

    // next state and registered datapath
    always_comb begin
        n_state   = r_state;
        n_word    = r_word;
        n_bit     = r_bit;
        n_clr     = r_clr;
        n_valid   = 1'b0;
        n_granted = r_granted;
        n_status  = r_status;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_ALLOC) begin
                        if (fdb_ext >= i_cfg.limit) begin
                            n_valid   = 1'b1;
                            n_granted = '0;
                            n_status  = ST_FULL;
                        end else begin
                            n_word  = fdb_word;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (BN_W'(i_block_id) >= i_cfg.limit) begin
                            n_valid   = 1'b1;
                            n_granted = '0;
                            n_status  = ST_RANGE;
                        end else begin
                            n_word  = id_word;
                            n_bit   = i_block_id[SH-1:0];
                            n_state = S_FREE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    n_valid   = 1'b1;
                    n_granted = grant_bn[ID_W-1:0];
                    n_status  = ST_OK;
                    n_state   = S_IDLE;
                end else if (r_word == last_word) begin
                    n_valid   = 1'b1;
                    n_granted = '0;
                    n_status  = ST_FULL;
                    n_state   = S_IDLE;
                end else begin
                    n_word = r_word + BN_W'(1);
                end
            end
            S_FREE: begin
                n_valid   = 1'b1;
                n_granted = '0;
                n_status  = ST_OK;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory controls and status outputs
    always_comb begin
        o_busy  = (r_state != S_IDLE);
        o_re    = 1'b0;
        o_raddr = AW'(r_word + BN_W'(1));
        o_we    = 1'b0;
        o_waddr = AW'(r_word);
        o_wdata = i_rdata;
        case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                o_wdata = '0;
            end
            S_IDLE: begin
                o_re    = accept;
                o_raddr = (i_kind == KIND_ALLOC) ? AW'(fdb_word) : AW'(id_word);
            end
            S_SCAN: begin
                // next word is fetched while this one is examined
                o_re    = 1'b1;
                o_we    = found;
                o_wdata = i_rdata | (WB'(1) << found_idx);
            end
            S_FREE: begin
                o_we    = 1'b1;
                o_wdata = i_rdata & ~(WB'(1) << r_bit);
            end
            default: begin
                o_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_bit     <= n_bit;
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    assign o_valid         = r_valid;
    assign o_granted_block = r_granted;
    assign o_status        = r_status;

endmodule
